[sv/assert_macros.svh]
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is asserted.
`define FLP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Clocked check that also holds during reset.
`define FLP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define FLP_ASSERT(lbl, clk, rst_n, prop)
`define FLP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[sv/flp_pkg.sv]
// Shared constants, codes and controller/datapath interface types.
`default_nettype none

package flp_pkg;

  // Table size; must be a power of two so the home slot is the low hash bits.
  localparam int unsigned SLOTS   = 256;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned COUNT_W = SLOT_W + 1;
  localparam int unsigned MAX_W   = 8;
  localparam int unsigned CMP_W   = (COUNT_W > MAX_W) ? COUNT_W : MAX_W;

  localparam int unsigned HASH_W  = 32;
  localparam int unsigned GROUP_W = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ENTRY_W = HASH_W + GROUP_W + VALUE_W;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 8'd153;

  // Operation codes
  localparam logic [1:0] OP_GET   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    RES_ZERO,   // found 0, value 0, status ok
    RES_HIT,    // found 1, value from slot
    RES_FOUND,  // found 1, value 0 (set update)
    RES_FULL    // set refused
  } res_sel_e;

  typedef struct packed {
    logic     hash_en;      // input transfer
    logic     key_load;     // last item: latch key hash and fields
    logic     probe_start;
    logic     probe_next;
    logic     rd_en;
    logic     wr_entry;
    logic     insert;
    logic     clear_all;
    logic     res_load;
    res_sel_e res_sel;
  } flp_cmd_t;

  typedef struct packed {
    logic used;
    logic match;
    logic last_probe;
    logic count_ok;
    logic op_set;
    logic op_clear;
  } flp_sts_t;

endpackage

`default_nettype wire

[sv/fnv1a_linear_probe_table.sv]
// Top level: FNV-1a keyed store with linear probing over a slot RAM.
//
//  channel  dir  handshake              payload
//  s_axis   in   tvalid/tready          tdata, tlast (key_last), tuser
//  m_axis   out  tvalid/tready          tdata, tuser
//  cfg      in   cfg_valid/cfg_ready    cfg_wdata (max_entries)
//
// A key byte item (tlast low) is accepted in the idle state, which holds tready high.
// Get/set: intake, then a read state and a compare state per slot probed, as the single slot
//   RAM port serves one registered read per probe; clear and unused codes pass through ST_FIN.
// Occupancy lives in per-slot flip-flops cleared at reset, so no clearing pass.
// A result waiting in the output register stalls only the final probe step and ST_FIN.
`default_nettype none

module fnv1a_linear_probe_table
  import flp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [55:0] s_axis_tdata_i,  // key_byte[7:0], group[23:8], value[55:24]
  input  wire logic        s_axis_tlast_i,
  input  wire logic [2:0]  s_axis_tuser_i,  // operation[1:0], byte_valid[2]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // value_out[31:0]
  output logic [1:0]       m_axis_tuser_o,  // found[0], status[1]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_wdata_i
);

  flp_cmd_t cmd;
  flp_sts_t sts;
  logic     found;
  logic     status;

  assign cfg_ready_o = 1'b1;

  flp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_last_i  (s_axis_tlast_i),
    .in_op_i    (s_axis_tuser_i[1:0]),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  flp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tuser_i[1:0]),
    .byte_valid_i(s_axis_tuser_i[2]),
    .key_byte_i  (s_axis_tdata_i[7:0]),
    .group_i     (s_axis_tdata_i[23:8]),
    .value_i     (s_axis_tdata_i[55:24]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_wdata_i (cfg_wdata_i),
    .found_o     (found),
    .value_out_o (m_axis_tdata_o),
    .status_o    (status)
  );

  assign m_axis_tuser_o = {status, found};

endmodule

`default_nettype wire

[sv/flp_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none

module flp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/flp_datapath.sv]
// Hash accumulator, probe pointer, slot store, occupancy and result registers.
`default_nettype none

`include "assert_macros.svh"

module flp_datapath
  import flp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire flp_cmd_t             cmd_i,
  output flp_sts_t                  sts_o,
  input  wire logic [1:0]           op_i,
  input  wire logic                 byte_valid_i,
  input  wire logic [7:0]           key_byte_i,
  input  wire logic [GROUP_W-1:0]   group_i,
  input  wire logic [VALUE_W-1:0]   value_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [MAX_W-1:0]     cfg_wdata_i,
  output logic                      found_o,
  output logic      [VALUE_W-1:0]   value_out_o,
  output logic                      status_o
);

  logic [HASH_W-1:0]  hash_q, hash_d;
  logic [HASH_W-1:0]  mix;
  logic [HASH_W-1:0]  key_hash_q;
  logic [GROUP_W-1:0] group_q;
  logic [VALUE_W-1:0] value_q;
  logic [1:0]         op_q;
  logic [SLOT_W-1:0]  ptr_q, ptr_d;
  logic [SLOT_W-1:0]  probe_cnt_q, probe_cnt_d;
  logic [SLOTS-1:0]   used_q;
  logic [COUNT_W-1:0] count_q;
  logic [MAX_W-1:0]   max_entries_q;
  logic [ENTRY_W-1:0] rdata;
  logic [HASH_W-1:0]  rd_hash;
  logic [GROUP_W-1:0] rd_group;
  logic [VALUE_W-1:0] rd_value;
  logic               found_q;
  logic [VALUE_W-1:0] value_out_q;
  logic               status_q;

  // FNV-1a step: xor the byte in, then multiply mod 2^32
  assign mix    = hash_q ^ {{(HASH_W-8){1'b0}}, key_byte_i};
  assign hash_d = byte_valid_i ? HASH_W'(mix * FNV_PRIME) : hash_q;

  always_comb begin
    ptr_d       = ptr_q;
    probe_cnt_d = probe_cnt_q;
    if (cmd_i.probe_start) begin
      ptr_d       = hash_d[SLOT_W-1:0];
      probe_cnt_d = '0;
    end else if (cmd_i.probe_next) begin
      ptr_d       = ptr_q + SLOT_W'(1);
      probe_cnt_d = probe_cnt_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q        <= FNV_BASIS;
      used_q        <= '0;
      count_q       <= '0;
      max_entries_q <= MAX_ENTRIES_RST;
    end else begin
      if (cmd_i.hash_en) begin
        hash_q <= cmd_i.key_load ? FNV_BASIS : hash_d;
      end
      if (cmd_i.clear_all) begin
        used_q  <= '0;
        count_q <= '0;
      end else if (cmd_i.insert) begin
        used_q[ptr_q] <= 1'b1;
        count_q       <= count_q + COUNT_W'(1);
      end
      if (cfg_we_i) begin
        max_entries_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) begin
      key_hash_q <= hash_d;
      group_q    <= group_i;
      value_q    <= value_i;
      op_q       <= op_i;
    end
    ptr_q       <= ptr_d;
    probe_cnt_q <= probe_cnt_d;
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        RES_HIT: begin
          found_q     <= 1'b1;
          value_out_q <= rd_value;
          status_q    <= 1'b0;
        end
        RES_FOUND: begin
          found_q     <= 1'b1;
          value_out_q <= '0;
          status_q    <= 1'b0;
        end
        RES_FULL: begin
          found_q     <= 1'b0;
          value_out_q <= '0;
          status_q    <= 1'b1;
        end
        default: begin
          found_q     <= 1'b0;
          value_out_q <= '0;
          status_q    <= 1'b0;
        end
      endcase
    end
  end

  flp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .re_i   (cmd_i.rd_en),
    .we_i   (cmd_i.wr_entry),
    .addr_i (ptr_q),
    .wdata_i({key_hash_q, group_q, value_q}),
    .rdata_o(rdata)
  );

  assign {rd_hash, rd_group, rd_value} = rdata;

  assign sts_o.used       = used_q[ptr_q];
  assign sts_o.match      = (rd_hash == key_hash_q) && (rd_group == group_q);
  assign sts_o.last_probe = (probe_cnt_q == SLOT_W'(SLOTS - 1));
  assign sts_o.count_ok   = CMP_W'(count_q) < CMP_W'(max_entries_q);
  assign sts_o.op_set     = (op_q == OP_SET);
  assign sts_o.op_clear   = (op_q == OP_CLEAR);

  assign found_o     = found_q;
  assign value_out_o = value_out_q;
  assign status_o    = status_q;

  `FLP_ASSERT(a_insert_counts, clk_i, rst_ni,
    cmd_i.insert && !cmd_i.clear_all |=> count_q == $past(count_q) + COUNT_W'(1))
  `FLP_ASSERT(a_clear_empties, clk_i, rst_ni,
    cmd_i.clear_all |=> count_q == '0 && used_q == '0)
  `FLP_ASSERT(a_insert_empty_slot, clk_i, rst_ni,
    cmd_i.insert |-> !used_q[ptr_q] && cmd_i.wr_entry)

endmodule

`default_nettype wire

[sv/flp_ctrl.sv]
// Controller: item intake, probe sequencing, table actions and result handoff.
`default_nettype none

`include "assert_macros.svh"

module flp_ctrl
  import flp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic     in_last_i,
  input  wire logic [1:0] in_op_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output flp_cmd_t      cmd_o,
  input  wire flp_sts_t sts_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       keep_probing;
  flp_cmd_t   cmd;

  assign out_free     = !out_valid_q || out_ready_i;
  assign keep_probing = sts_i.used && !sts_i.match && !sts_i.last_probe;

  always_comb begin
    cmd         = '0;
    cmd.res_sel = RES_ZERO;
    state_d     = state_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.hash_en = 1'b1;
          if (in_last_i) begin
            cmd.key_load = 1'b1;
            if (in_op_i == OP_GET || in_op_i == OP_SET) begin
              cmd.probe_start = 1'b1;
              state_d         = ST_RD;
            end else begin
              state_d = ST_FIN;
            end
          end
        end
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        if (keep_probing) begin
          cmd.probe_next = 1'b1;
          state_d        = ST_RD;
        end else if (out_free) begin
          // slot data stays in the RAM output register while the result waits
          cmd.res_load = 1'b1;
          state_d      = ST_IDLE;
          if (sts_i.used && sts_i.match) begin
            if (sts_i.op_set) begin
              cmd.wr_entry = 1'b1;
              cmd.res_sel  = RES_FOUND;
            end else begin
              cmd.res_sel = RES_HIT;
            end
          end else if (sts_i.op_set && !sts_i.used && sts_i.count_ok) begin
            cmd.wr_entry = 1'b1;
            cmd.insert   = 1'b1;
          end else if (sts_i.op_set) begin
            cmd.res_sel = RES_FULL;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.res_load  = 1'b1;
          cmd.clear_all = sts_i.op_clear;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  `FLP_ASSERT(a_result_presented, clk_i, rst_ni,
    cmd.res_load |=> out_valid_q)
  `FLP_ASSERT(a_wait_for_output, clk_i, rst_ni,
    state_q == ST_CMP && !keep_probing && !out_free |=> state_q == ST_CMP)
  `FLP_ASSERT(a_write_only_on_set, clk_i, rst_ni,
    cmd.wr_entry |-> state_q == ST_CMP && sts_i.op_set && out_free)
  `FLP_ASSERT_ALWAYS(a_no_write_in_reset, clk_i,
    !rst_ni |-> !cmd.wr_entry || state_q == ST_CMP)

endmodule

`default_nettype wire
